[rtl/isl_pkg.sv]
// Package for the indexed sequence list: sizes, operation and status codes,
// and the control word broadcast to the element cells. No dependencies.
`default_nettype none

package isl_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CNT_W    = 5;   // Holds 0 .. CAPACITY.
  localparam int unsigned DATA_W   = 32;

  typedef enum logic [2:0] {
    OP_ADD_HEAD = 3'd0,
    OP_ADD_TAIL = 3'd1,
    OP_INSERT   = 3'd2,
    OP_REM_HEAD = 3'd3,
    OP_REM_TAIL = 3'd4,
    OP_REMOVE   = 3'd5,
    OP_LIST     = 3'd6,
    OP_NOP      = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADIDX = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ACT_HOLD   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_ROTATE = 2'd3
  } act_e;

  // Control word shared by every cell. For a rotation, pos is the index of
  // the tail cell, which takes the head element.
  typedef struct packed {
    act_e              act;
    logic [CNT_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/isl_cell.sv]
// One element cell of the indexed sequence list. Holds one 32-bit word and
// trades it with its neighbors. Depends on isl_pkg.
`default_nettype none

module isl_cell (
  input  wire logic                          clk_i,
  input  wire isl_pkg::cell_ctrl_t           ctrl_i,
  input  wire logic [isl_pkg::CNT_W-1:0]     idx_i,
  input  wire logic [isl_pkg::DATA_W-1:0]    left_i,
  input  wire logic [isl_pkg::DATA_W-1:0]    right_i,
  input  wire logic [isl_pkg::DATA_W-1:0]    head_i,
  output logic      [isl_pkg::DATA_W-1:0]    data_o
);

  logic [isl_pkg::DATA_W-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    unique case (ctrl_i.act)
      isl_pkg::ACT_INSERT: begin
        if (idx_i == ctrl_i.pos) begin
          data_d = ctrl_i.value;
        end else if (idx_i > ctrl_i.pos) begin
          data_d = left_i;
        end
      end
      isl_pkg::ACT_REMOVE: begin
        if (idx_i >= ctrl_i.pos) begin
          data_d = right_i;
        end
      end
      isl_pkg::ACT_ROTATE: begin
        // The occupied part turns by one place toward the head.
        if (idx_i == ctrl_i.pos) begin
          data_d = head_i;
        end else if (idx_i < ctrl_i.pos) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

[rtl/indexed_sequence_list_unit.sv]
// Top level of the indexed sequence list: a row of element cells and the
// operation sequencer. Depends on isl_pkg and isl_cell.
`default_nettype none

// Holds up to CAPACITY signed words in order from the head. An operation is
// taken when start is high and busy is low; its result appears in the next
// cycle for one cycle with result_valid_o, and the receiver cannot hold it
// off. Adds, inserts and removals move all cells at once and leave busy low,
// so a new operation can follow in the next cycle. A listing of n elements
// rotates the cell row once per cycle with busy high throughout, giving one
// element per cycle; its first element passes through the state register and
// then the result registers, and the next transfer can come once busy falls.
// Listing an empty list gives one result and leaves busy low.
module indexed_sequence_list_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [2:0]                         op_i,
  input  wire logic [4:0]                         position_i,
  input  wire logic signed [31:0]                 value_i,
  output logic                                    result_valid_o,
  output logic [1:0]                              status_o,
  output logic signed [31:0]                      element_o,
  output logic [4:0]                              count_o,
  output logic                                    last_o
);

  localparam int unsigned CAP = isl_pkg::CAPACITY;
  localparam int unsigned CW  = isl_pkg::CNT_W;
  localparam int unsigned DW  = isl_pkg::DATA_W;

  localparam logic STATE_IDLE = 1'b0;
  localparam logic STATE_LIST = 1'b1;

  localparam logic [CW-1:0] CAP_CNT = CW'(CAP);
  localparam logic [CW-1:0] ONE     = CW'(1);

  logic state_d, state_q;
  logic [CW-1:0] occ_d, occ_q;
  logic [CW-1:0] k_d, k_q;

  logic              vld_d, vld_q;
  logic [1:0]        st_d, st_q;
  logic [DW-1:0]     el_d, el_q;
  logic              last_d, last_q;

  isl_pkg::cell_ctrl_t ctrl;
  logic [DW-1:0] cell_data [CAP];

  logic          accept;
  isl_pkg::op_e  op;
  logic [CW-1:0] ins_idx;

  assign accept = start && !busy;
  assign op     = isl_pkg::op_e'(op_i);

  always_comb begin
    unique case (op)
      isl_pkg::OP_ADD_HEAD: ins_idx = '0;
      isl_pkg::OP_ADD_TAIL: ins_idx = occ_q;
      default:              ins_idx = position_i;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    occ_d      = occ_q;
    k_d        = k_q;
    vld_d      = 1'b0;
    st_d       = st_q;
    el_d       = '0;
    last_d     = 1'b1;
    ctrl.act   = isl_pkg::ACT_HOLD;
    ctrl.pos   = '0;
    ctrl.value = value_i;

    if (state_q == STATE_LIST) begin
      vld_d    = 1'b1;
      st_d     = isl_pkg::ST_OK;
      el_d     = cell_data[0];
      last_d   = (k_q == occ_q - ONE);
      ctrl.act = isl_pkg::ACT_ROTATE;
      ctrl.pos = occ_q - ONE;
      k_d      = k_q + ONE;
      if (last_d) begin
        state_d = STATE_IDLE;
      end
    end else if (accept) begin
      vld_d = 1'b1;
      st_d  = isl_pkg::ST_OK;
      unique case (op)
        isl_pkg::OP_ADD_HEAD, isl_pkg::OP_ADD_TAIL, isl_pkg::OP_INSERT: begin
          // The index is checked before fullness.
          if (ins_idx > occ_q) begin
            st_d = isl_pkg::ST_BADIDX;
          end else if (occ_q == CAP_CNT) begin
            st_d = isl_pkg::ST_FULL;
          end else begin
            ctrl.act = isl_pkg::ACT_INSERT;
            ctrl.pos = ins_idx;
            occ_d    = occ_q + ONE;
          end
        end
        isl_pkg::OP_REM_HEAD, isl_pkg::OP_REM_TAIL: begin
          if (occ_q == '0) begin
            st_d = isl_pkg::ST_EMPTY;
          end else begin
            ctrl.act = isl_pkg::ACT_REMOVE;
            ctrl.pos = (op == isl_pkg::OP_REM_HEAD) ? '0 : occ_q - ONE;
            occ_d    = occ_q - ONE;
          end
        end
        isl_pkg::OP_REMOVE: begin
          if (position_i >= occ_q) begin
            st_d = isl_pkg::ST_BADIDX;
          end else begin
            ctrl.act = isl_pkg::ACT_REMOVE;
            ctrl.pos = position_i;
            occ_d    = occ_q - ONE;
          end
        end
        isl_pkg::OP_LIST: begin
          if (occ_q == '0) begin
            st_d = isl_pkg::ST_EMPTY;
          end else begin
            // Results come from the listing cycles that follow.
            vld_d   = 1'b0;
            k_d     = '0;
            state_d = STATE_LIST;
          end
        end
        default: st_d = isl_pkg::ST_OK;
      endcase
    end
  end

  for (genvar g = 0; g < CAP; g++) begin : g_cell
    logic [DW-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = value_i;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == CAP - 1) begin : g_last
      assign right = cell_data[g];
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end
    isl_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .idx_i  (CW'(g)),
      .left_i (left),
      .right_i(right),
      .head_i (cell_data[0]),
      .data_o (cell_data[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_IDLE;
      occ_q   <= '0;
      k_q     <= '0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      k_q     <= k_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q   <= st_d;
    el_q   <= el_d;
    last_q <= last_d;
  end

  assign busy           = (state_q == STATE_LIST);
  assign result_valid_o = vld_q;
  assign status_o       = st_q;
  assign element_o      = el_q;
  assign count_o        = occ_q;
  assign last_o         = last_q;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CAP_CNT)
    else $error("occupancy above capacity");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op != isl_pkg::OP_LIST) |=> (result_valid_o && last_o))
    else $error("missing single result after operation");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o == isl_pkg::ST_FULL) |-> (count_o == CAP_CNT))
    else $error("full status with room left");

  a_list_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (occ_q != '0 && $stable(occ_q)))
    else $error("occupancy changed during a listing");
`endif

endmodule

`default_nettype wire
